// File: design/bem_pkg.sv
// Shared types, constants and command/status structs for the byte entropy meter.
package bem_pkg;

	localparam int MAX_LEN_LOG2 = 24;
	localparam int FRAC_BITS    = 12;
	localparam int LOG_FRAC     = 24;
	localparam int CNT_W        = MAX_LEN_LOG2 + 1;
	localparam int INT_W        = 5;
	localparam int LOG_W        = INT_W + LOG_FRAC;
	localparam int SUM_W        = 54;
	localparam int DIV_CNT_W    = 6;
	localparam int ITER_W       = 5;

	localparam logic [0:0] CFG_HIGH_THRESHOLD = 1'd0;
	localparam logic [0:0] CFG_HIGH_WEIGHT    = 1'd1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [15:0] entropy_q;
		logic        above_threshold;
		logic [7:0]  score;
		logic        length_overflow;
	} res_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHK,
		ST_WR,
		ST_BEGIN,
		ST_BIN_RD,
		ST_BIN_CHK,
		ST_NORM,
		ST_SQ,
		ST_MUL,
		ST_ACC,
		ST_NEXT,
		ST_LN_LOAD,
		ST_LN_NORM,
		ST_LN_SQ,
		ST_DIV,
		ST_FIN
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;
		logic hist_rd;
		logic hist_wr;
		logic ovf_set;
		logic bin_rd;
		logic log_load;
		logic log_src_n;
		logic log_norm;
		logic log_sq;
		logic mul;
		logic acc;
		logic idx_inc;
		logic ln_store;
		logic div_load;
		logic div_step;
		logic finish;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic full;
		logic last;
		logic n_zero;
		logic f_gt1;
		logic norm_done;
		logic sq_last;
		logic idx_last;
		logic div_last;
	} sts_t;

endpackage

// File: design/byte_entropy_meter_top.sv
// Top level of the byte entropy meter: config registers, controller and datapath.
// Usage:
//  Input: a transaction is taken at a clock edge with start high and busy low;
//  data_in carries one byte and the last-byte mark. Each byte goes through
//  accept, histogram read and histogram write to the memory.
//  After the last byte the entropy pass runs: each bin is read and checked, and
//  each bin with count f > 1 is normalized and squared in the shared log2 unit,
//  then multiplied and accumulated; then log2 of the count is taken and the
//  divider forms sum / count. An empty run skips the pass. The result then shows on result
//  with done high for one cycle; the receiver cannot stall it. busy is low again in that
//  same cycle, and histogram, count and overflow flag are already cleared.
//  Bytes beyond 2^24 in one run are dropped and flagged in length_overflow.
//  Config: cfg_we writes cfg_wdata to register cfg_idx (0 threshold, 1 weight) at once;
//  the user must write only while idle (the block does not enforce it). Reset (arst_n low)
//  clears the histogram valid bits, count and state and loads the register defaults.
module byte_entropy_meter_top import bem_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    data_in,
	output logic        done,
	output res_item_t   result,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_idx,
	input  logic [15:0] cfg_wdata
);

	logic [15:0] high_threshold_q;
	logic [7:0]  high_weight_q;
	cmd_t        cmd;
	sts_t        sts;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_threshold_q <= 16'd30720;
			high_weight_q    <= 8'd10;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_HIGH_THRESHOLD: high_threshold_q <= cfg_wdata;
				CFG_HIGH_WEIGHT:    high_weight_q    <= cfg_wdata[7:0];
				default:            ;
			endcase
		end
	end

	bem_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	bem_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.data_in        (data_in),
		.high_threshold (high_threshold_q),
		.high_weight    (high_weight_q),
		.sts            (sts),
		.result         (result),
		.done           (done)
	);

`ifndef ASSERT_OFF
	// A result comes only at the end of a busy pass
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy)) else $error("result without busy pass");

	// One result per run: strobes never back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe repeated");

	// Score is zero unless the flag is set
	a_score_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.above_threshold) |-> (result.score == 8'd0))
		else $error("score without threshold flag");
`endif

endmodule

// File: design/bem_ctrl.sv
// Controller state machine sequencing histogram updates and the entropy pass.
module bem_ctrl import bem_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output cmd_t cmd,
	output logic busy
);

	state_t state_q, state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:    if (start) state_d = ST_CHK;
			ST_CHK: begin
				if (!sts.full) state_d = ST_WR;
				else if (sts.last) state_d = ST_BEGIN;
				else state_d = ST_IDLE;
			end
			ST_WR:      state_d = sts.last ? ST_BEGIN : ST_IDLE;
			ST_BEGIN:   state_d = sts.n_zero ? ST_FIN : ST_BIN_RD;
			ST_BIN_RD:  state_d = ST_BIN_CHK;
			ST_BIN_CHK: state_d = sts.f_gt1 ? ST_NORM : ST_NEXT;
			ST_NORM:    if (sts.norm_done) state_d = ST_SQ;
			ST_SQ:      if (sts.sq_last) state_d = ST_MUL;
			ST_MUL:     state_d = ST_ACC;
			ST_ACC:     state_d = ST_NEXT;
			ST_NEXT:    state_d = sts.idx_last ? ST_LN_LOAD : ST_BIN_RD;
			ST_LN_LOAD: state_d = ST_LN_NORM;
			ST_LN_NORM: if (sts.norm_done) state_d = ST_LN_SQ;
			ST_LN_SQ:   if (sts.sq_last) state_d = ST_DIV;
			ST_DIV:     if (sts.div_last) state_d = ST_FIN;
			ST_FIN:     state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			ST_CHK: begin
				cmd.hist_rd = !sts.full;
				cmd.ovf_set = sts.full;
			end
			ST_WR:      cmd.hist_wr = 1'b1;
			ST_BEGIN:   ;
			ST_BIN_RD:  cmd.bin_rd = 1'b1;
			ST_BIN_CHK: cmd.log_load = sts.f_gt1;
			ST_NORM,
			ST_LN_NORM: cmd.log_norm = !sts.norm_done;
			ST_SQ: begin
				cmd.log_sq = 1'b1;
			end
			ST_MUL:     cmd.mul = 1'b1;
			ST_ACC:     cmd.acc = 1'b1;
			ST_NEXT:    cmd.idx_inc = 1'b1;
			ST_LN_LOAD: begin
				cmd.log_load  = 1'b1;
				cmd.log_src_n = 1'b1;
			end
			ST_LN_SQ: begin
				cmd.log_sq = 1'b1;
				cmd.ln_store = sts.sq_last;
				cmd.div_load = sts.sq_last;
			end
			ST_DIV:     cmd.div_step = 1'b1;
			ST_FIN:     cmd.finish = 1'b1;
			default:    ;
		endcase
	end

endmodule

// File: design/bem_dpath.sv
// Datapath: histogram memory, log2 unit, accumulator, divider and result register.
module bem_dpath import bem_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	input  in_item_t    data_in,
	input  logic [15:0] high_threshold,
	input  logic [7:0]  high_weight,
	output sts_t        sts,
	output res_item_t   result,
	output logic        done
);

	logic [CNT_W-1:0]     mem [256];
	logic [CNT_W-1:0]     mem_rd_q;
	logic                 vld_rd_q;
	logic [255:0]         valid_q;
	logic [7:0]           addr_q;
	logic                 last_q;
	logic [CNT_W-1:0]     count_q;
	logic                 ovf_q;
	logic [7:0]           idx_q;
	logic [CNT_W-1:0]     f;
	logic [7:0]           raddr;

	logic [31:0]          m_q;
	logic [INT_W-1:0]     e_q;
	logic [LOG_FRAC-1:0]  frac_q;
	logic [ITER_W-1:0]    it_q;
	logic [63:0]          sq;
	logic [32:0]          sq_t;

	logic [SUM_W-1:0]     prod_s1;
	logic [SUM_W-1:0]     sum_q;
	logic [LOG_W-1:0]     ln_q;

	logic [SUM_W-1:0]     quo_q;
	logic [CNT_W-1:0]     rem_q;
	logic [DIV_CNT_W-1:0] dcnt_q;
	logic [CNT_W:0]       trial;
	logic                 fits;

	logic [SUM_W-1:0]     h_diff;
	logic [SUM_W-1:0]     h_rnd;
	logic [15:0]          ent;
	logic                 above;
	res_item_t            result_q;
	logic                 done_q;

	assign f     = vld_rd_q ? mem_rd_q : '0;
	assign raddr = cmd.bin_rd ? idx_q : addr_q;

	// Histogram memory, registered read
	always_ff @(posedge clk) begin
		if (cmd.hist_wr) begin
			mem[addr_q] <= f + CNT_W'(1);
		end
		if (cmd.hist_rd || cmd.bin_rd) begin
			mem_rd_q <= mem[raddr];
		end
	end

	// Per-bin valid bits, byte counter, overflow and bin index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			idx_q    <= '0;
			addr_q   <= '0;
			last_q   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				addr_q <= data_in.data_byte;
				last_q <= data_in.last_byte;
			end
			if (cmd.hist_rd || cmd.bin_rd) begin
				vld_rd_q <= valid_q[raddr];
			end
			if (cmd.hist_wr) begin
				valid_q[addr_q] <= 1'b1;
				count_q         <= count_q + CNT_W'(1);
			end
			if (cmd.ovf_set) begin
				ovf_q <= 1'b1;
			end
			if (cmd.idx_inc) begin
				idx_q <= idx_q + 8'd1;
			end
			if (cmd.finish) begin
				valid_q <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
				idx_q   <= '0;
			end
		end
	end

	// Log2 unit: normalize one bit a cycle, then one squaring step a cycle
	assign sq   = m_q * m_q;
	assign sq_t = sq[63:31];

	always_ff @(posedge clk) begin
		if (cmd.log_load) begin
			m_q    <= 32'(cmd.log_src_n ? count_q : f);
			e_q    <= INT_W'(31);
			frac_q <= '0;
			it_q   <= '0;
		end else if (cmd.log_norm) begin
			m_q <= {m_q[30:0], 1'b0};
			e_q <= e_q - INT_W'(1);
		end else if (cmd.log_sq) begin
			it_q <= it_q + ITER_W'(1);
			if (sq_t[32]) begin
				m_q    <= sq_t[32:1];
				frac_q <= {frac_q[LOG_FRAC-2:0], 1'b1};
			end else begin
				m_q    <= sq_t[31:0];
				frac_q <= {frac_q[LOG_FRAC-2:0], 1'b0};
			end
		end
	end

	// f * log2(f) product and running sum
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s1 <= SUM_W'(f * {e_q, frac_q});
		end
		if (cmd.ln_store) begin
			ln_q <= {e_q, frac_q[LOG_FRAC-2:0], sq_t[32]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (cmd.finish) begin
			sum_q <= '0;
		end else if (cmd.acc) begin
			sum_q <= sum_q + prod_s1;
		end
	end

	// Restoring divider: sum / count, one quotient bit a cycle
	assign trial = {rem_q, quo_q[SUM_W-1]};
	assign fits  = trial >= {1'b0, count_q};

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			quo_q  <= sum_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= fits ? CNT_W'(trial - {1'b0, count_q}) : trial[CNT_W-1:0];
			quo_q  <= {quo_q[SUM_W-2:0], fits};
			dcnt_q <= dcnt_q + DIV_CNT_W'(1);
		end
	end

	// Final subtraction, rounding, saturation and threshold compare
	assign h_diff = ({{(SUM_W-LOG_W){1'b0}}, ln_q} > quo_q)
		? ({{(SUM_W-LOG_W){1'b0}}, ln_q} - quo_q) : '0;
	assign h_rnd  = (h_diff + (SUM_W'(1) << (LOG_FRAC - 1 - FRAC_BITS)))
		>> (LOG_FRAC - FRAC_BITS);
	assign ent    = (count_q == '0) ? 16'd0
		: ((h_rnd > SUM_W'(16'hFFFF)) ? 16'hFFFF : h_rnd[15:0]);
	assign above  = ent > high_threshold;

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.entropy_q       <= ent;
			result_q.above_threshold <= above;
			result_q.score           <= above ? high_weight : 8'd0;
			result_q.length_overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign result = result_q;
	assign done   = done_q;

	// Status back to the controller
	assign sts.full      = count_q[CNT_W-1];
	assign sts.last      = last_q;
	assign sts.n_zero    = (count_q == '0);
	assign sts.f_gt1     = (f > CNT_W'(1));
	assign sts.norm_done = m_q[31];
	assign sts.sq_last   = (it_q == ITER_W'(LOG_FRAC - 1));
	assign sts.idx_last  = (idx_q == 8'd255);
	assign sts.div_last  = (dcnt_q == DIV_CNT_W'(SUM_W - 1));

endmodule
